/* sv/fbpa_pkg.sv */
package fbpa_pkg;

    localparam int MAX_BLOCKS     = 256;
    localparam int MIN_BLOCK_SIZE = 8;
    localparam int ADDR_BITS      = 32;

    localparam int SIZE_W   = 16;                       // block_size register
    localparam int CNT_W    = 9;                        // block_count register and counts
    localparam int IDX_W    = $clog2(MAX_BLOCKS);       // block index
    localparam int LINK_W   = IDX_W + 1;                // index plus null marker
    localparam int SPAN_W   = SIZE_W + CNT_W;           // size times count
    localparam int STEP_W   = $clog2(SPAN_W + 1);       // divider step counter
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int OUT_BITS = 2 + ADDR_BITS + CNT_W + CNT_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0]  USED_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE  = 2'd0,
        REG_SIZE  = 2'd1,
        REG_COUNT = 2'd2
    } t_reg_idx;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RANGE    = 2'd2,
        ST_MISALIGN = 2'd3
    } t_status;

    // divider handshake toward the sequencer
    typedef struct packed {
        logic done;
        logic busy;
    } t_div_stat;

endpackage

/* sv/fbpa_divider.sv */
module fbpa_divider
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SPAN_W-1:0] i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output t_div_stat         o_stat,
    output logic [SPAN_W-1:0] o_quotient,
    output logic [SIZE_W-1:0] o_remainder
);

    // restoring divider, one quotient bit per cycle
    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [SPAN_W-1:0] r_quo;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;

    logic [SIZE_W:0]   w_shift;
    logic [SIZE_W-1:0] w_sub;
    logic              w_ge;
    logic [SIZE_W-1:0] n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[SPAN_W-1]};
        // only taken when shift >= divisor, so the low bits hold the difference
        w_sub   = w_shift[SIZE_W-1:0] - r_div;
        w_ge    = (w_shift >= {1'b0, r_div});
        n_rem   = w_ge ? w_sub : w_shift[SIZE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(SPAN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SPAN_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.busy = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* sv/fixed_block_pool_allocator.sv */
// Fixed-size block pool allocator. The pool is base_address plus block_count
// blocks of block_size bytes (sizes below 8 count as 8, counts above 256 as
// 256); each register write re-initializes it. Requests arrive on the slave
// stream, tuser = operation (0 alloc, 1 free), tdata = address to free. Each
// request yields one response: status, block address (0 unless an alloc
// succeeded), used and free counts, pool-full flag. Freed blocks are reused
// LIFO; a fresh pool hands out blocks from the highest index down. Double
// frees are not detected. One request is in flight at a time. An alloc runs
// the prepare, multiply and add steps (prepare alone when the pool is empty);
// a free rejected for range stops after the check step, any other free waits
// for the 25-step serial divider that turns the block offset into an index;
// a response still held downstream holds the finish step until it is taken.
// The response register lets the next request be accepted while a response
// still waits downstream.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [ADDR_BITS-1:0]  i_s_axis_tdata,  // [31:0] address
    input  logic                  i_s_axis_tuser,  // [0] operation
    // response stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [1:0] status, [33:2] block_address, [42:34] used_blocks,
    // [51:43] free_blocks, [52] pool_full, [55:53] zero
    output logic [OUT_W-1:0]      o_m_axis_tdata
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_AMUL  = 7'b0010000,
        S_AADD  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;

    // configuration
    logic [ADDR_BITS-1:0] r_base;
    logic [SIZE_W-1:0]    r_size;
    logic [CNT_W-1:0]     r_count;

    // pool state
    logic [LINK_W-1:0]    r_head;
    logic [CNT_W-1:0]     r_fresh;
    logic [CNT_W-1:0]     r_used;
    logic [LINK_W-1:0]    r_mem [MAX_BLOCKS];
    logic [LINK_W-1:0]    r_link;

    // per-request working registers
    t_op                  r_op;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_offset;
    logic                 r_below;
    logic [SPAN_W-1:0]    r_prod;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_from_list;
    t_status              r_status;
    logic [ADDR_BITS-1:0] r_baddr;

    // response register
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    logic [SIZE_W-1:0]    w_eff_size;
    logic [CNT_W-1:0]     w_eff_count;
    logic [CNT_W-1:0]     w_mul_b;
    logic [SPAN_W-1:0]    w_prod;
    logic [ADDR_BITS:0]   w_diff;
    logic [CNT_W-1:0]     w_fresh_dec;
    logic [CNT_W-1:0]     w_free_cnt;
    logic                 w_full;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_div_start;
    logic                 w_push;
    logic [IDX_W-1:0]     w_push_idx;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     n_eff_count;

    t_div_stat            w_div_stat;
    logic [SPAN_W-1:0]    w_quo;
    logic [SIZE_W-1:0]    w_rem;

    always_comb begin
        w_eff_size  = (r_size < SIZE_W'(MIN_BLOCK_SIZE)) ? SIZE_W'(MIN_BLOCK_SIZE) : r_size;
        w_eff_count = (r_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : r_count;
        // one multiplier, shared: span check on a free, index scaling on an alloc
        w_mul_b     = (r_state == S_AMUL) ? CNT_W'(r_idx) : w_eff_count;
        w_prod      = SPAN_W'({{CNT_W{1'b0}}, w_eff_size} * {{SIZE_W{1'b0}}, w_mul_b});
        w_diff      = {1'b0, r_addr} - {1'b0, r_base};
        w_fresh_dec = r_fresh - 1'b1;
        w_free_cnt  = (w_eff_count > r_used) ? (w_eff_count - r_used) : '0;
        w_full      = r_head[IDX_W] && (r_fresh == '0);
        n_count     = (i_cfg_index == REG_COUNT) ? i_cfg_wdata[CNT_W-1:0] : r_count;
        n_eff_count = (n_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : n_count;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_div_start     = (r_state == S_CHECK) && !r_below &&
                             (r_offset < {{(ADDR_BITS-SPAN_W){1'b0}}, r_prod});
    assign w_push          = (r_state == S_DIV) && w_div_stat.done && (w_rem == '0);
    assign w_push_idx      = w_quo[IDX_W-1:0];

    fbpa_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_offset[SPAN_W-1:0]),
        .i_divisor   (w_eff_size),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // link store: push on a good free, registered read on an alloc
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_push_idx] <= r_head;
        end
        if (r_state == S_PREP && r_op == OP_ALLOC) begin
            r_link <= r_mem[r_head[IDX_W-1:0]];
        end
    end

    // sequencer and pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_size      <= SIZE_W'(8);
            r_count     <= CNT_W'(256);
            r_head      <= NULL_LINK;
            r_fresh     <= CNT_W'(MAX_BLOCKS);
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // loads out of the finish step, holds until taken downstream
            r_out_valid <= ((r_state == S_FIN) && w_out_free) ||
                           (r_out_valid && !i_m_axis_tready);

            if (i_cfg_we && (i_cfg_index == REG_BASE || i_cfg_index == REG_SIZE ||
                             i_cfg_index == REG_COUNT)) begin
                unique case (i_cfg_index)
                    REG_BASE:  r_base  <= i_cfg_wdata[ADDR_BITS-1:0];
                    REG_SIZE:  r_size  <= i_cfg_wdata[SIZE_W-1:0];
                    default:   r_count <= i_cfg_wdata[CNT_W-1:0];
                endcase
                r_head  <= NULL_LINK;
                r_fresh <= n_eff_count;
                r_used  <= '0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_op == OP_FREE) begin
                        r_state <= S_CHECK;
                    end else if (!r_head[IDX_W]) begin
                        r_state <= S_AMUL;
                    end else if (r_fresh != '0) begin
                        r_fresh <= w_fresh_dec;
                        r_state <= S_AMUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_CHECK: begin
                    r_state <= w_div_start ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        if (w_push) begin
                            r_head <= {1'b0, w_push_idx};
                            if (r_used != '0) begin
                                r_used <= r_used - 1'b1;
                            end
                        end
                        r_state <= S_FIN;
                    end
                end
                S_AMUL: begin
                    if (r_from_list) begin
                        r_head <= r_link;
                    end
                    r_state <= S_AADD;
                end
                S_AADD: begin
                    if (r_used != USED_MAX) begin
                        r_used <= r_used + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // request payload and per-step results
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op     <= t_op'(i_s_axis_tuser);
                    r_addr   <= i_s_axis_tdata;
                    r_status <= ST_OK;
                    r_baddr  <= '0;
                end
            end
            S_PREP: begin
                r_prod   <= w_prod;
                r_offset <= w_diff[ADDR_BITS-1:0];
                r_below  <= w_diff[ADDR_BITS];
                if (r_op == OP_ALLOC) begin
                    if (!r_head[IDX_W]) begin
                        r_idx       <= r_head[IDX_W-1:0];
                        r_from_list <= 1'b1;
                    end else begin
                        r_idx       <= w_fresh_dec[IDX_W-1:0];
                        r_from_list <= 1'b0;
                        if (r_fresh == '0) begin
                            r_status <= ST_EMPTY;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (!w_div_start) begin
                    r_status <= ST_RANGE;
                end
            end
            S_DIV: begin
                if (w_div_stat.done && w_rem != '0) begin
                    r_status <= ST_MISALIGN;
                end
            end
            S_AMUL: begin
                r_prod <= w_prod;
            end
            S_AADD: begin
                r_baddr <= r_base + {{(ADDR_BITS-SPAN_W){1'b0}}, r_prod};
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_out_data <= OUT_W'({w_full, w_free_cnt, r_used, r_baddr, r_status});
                end
            end
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // head is either a block index or the null marker
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= NULL_LINK)
        else $error("free list head beyond null marker");

    // never-issued blocks never exceed the built capacity
    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= CNT_W'(MAX_BLOCKS))
        else $error("fresh block count beyond capacity");

    // a response only appears out of the finish step
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_FIN))
        else $error("response raised outside finish step");

    // divider runs and finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_stat.busy || w_div_stat.done) |-> (r_state == S_DIV))
        else $error("divider active with no free pending");

endmodule

/* tb/sv/tb_fixed_block_pool_allocator.sv */
module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    // quiet cycles allowed: longest is the output hold-off plus a free's divider time
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_REQS     = 200;
    localparam int N_PHASES       = 8;
    localparam int N_ROWS         = 33;

    // one response, unpacked from m_axis_tdata
    typedef struct packed {
        t_status          status;
        logic [31:0]      blk_addr;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] avail;
        logic             full;
    } pool_resp_t;

    // directed stimulus row: either a register write or a request;
    // known rows carry status and block address typed in by hand
    typedef struct packed {
        bit          is_cfg;
        t_reg_idx    reg_sel;
        t_op         op;
        logic [31:0] value;
        bit          known;
        t_status     k_status;
        logic [31:0] k_addr;
    } dir_row_t;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata     = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [ADDR_BITS-1:0]  i_s_axis_tdata  = '0;   // [31:0] address
    logic                  i_s_axis_tuser  = 1'b0; // [0] operation
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [1:0] status, [33:2] block_address, [42:34] used_blocks,
    // [51:43] free_blocks, [52] pool_full
    logic [OUT_W-1:0]      o_m_axis_tdata;

    fixed_block_pool_allocator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Pool shadow: registers, free-list links, stack head, fresh count
    // ---------------------------------------------------------------
    logic [31:0]       base_r;
    logic [SIZE_W-1:0] size_r;
    logic [CNT_W-1:0]  count_r;
    logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
    logic [LINK_W-1:0] head_q;
    logic [CNT_W-1:0]  fresh_q;
    logic [CNT_W-1:0]  used_q;

    pool_resp_t        resp_q [$];   // responses still owed by the block
    logic [31:0]       live_q [$];   // addresses handed out and not yet returned

    int send_pct = 0;   // chance per cycle that the sender idles
    int rcv_pct  = 0;   // chance per cycle that the receiver stalls
    bit hold_go  = 1'b0;
    int n_bad    = 0;
    int n_resp   = 0;
    int n_cfg    = 0;
    int st_cnt [4] = '{0, 0, 0, 0};

    function automatic longint unsigned eff_size();
        return (size_r < MIN_BLOCK_SIZE) ? longint'(MIN_BLOCK_SIZE) : longint'(size_r);
    endfunction

    function automatic longint unsigned eff_count();
        return (count_r > MAX_BLOCKS) ? longint'(MAX_BLOCKS) : longint'(count_r);
    endfunction

    // Advances the shadow pool by one request and returns its response.
    function automatic pool_resp_t pool_step(t_op op, logic [31:0] a);
        longint unsigned sz, cnt, off;
        logic [LINK_W-1:0] idx;
        pool_resp_t r;
        sz  = eff_size();
        cnt = eff_count();
        r = '0;
        r.status = ST_OK;
        idx = '0;
        if (op == OP_ALLOC) begin
            // recycled blocks first (LIFO), then fresh ones from the top down
            if (head_q < MAX_BLOCKS) begin
                idx    = head_q;
                head_q = link_mem[idx[IDX_W-1:0]];
            end else if (fresh_q != 0 && fresh_q <= MAX_BLOCKS) begin
                fresh_q = fresh_q - 1'b1;
                idx     = fresh_q;
            end else begin
                r.status = ST_EMPTY;
            end
            if (r.status == ST_OK) begin
                r.blk_addr = 32'(longint'(base_r) + longint'(idx) * sz);
                if (used_q != USED_MAX) used_q = used_q + 1'b1;
            end
        end else if (a < base_r) begin
            r.status = ST_RANGE;
        end else begin
            off = longint'(a) - longint'(base_r);
            if (off >= sz * cnt) begin
                r.status = ST_RANGE;
            end else if (off % sz != 0) begin
                r.status = ST_MISALIGN;
            end else begin
                // no double-free check: the block just goes on the stack again
                idx                        = LINK_W'(off / sz);
                link_mem[idx[IDX_W-1:0]]   = head_q;
                head_q                     = idx;
                if (used_q != 0) used_q = used_q - 1'b1;
            end
        end
        r.used  = used_q;
        r.avail = (cnt > used_q) ? CNT_W'(cnt - used_q) : '0;
        r.full  = (head_q >= MAX_BLOCKS) && (fresh_q == 0);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side. Inputs move at the falling edge; acceptance is seen
    // at the rising edge, where the expected response gets queued.
    // ---------------------------------------------------------------
    task automatic push_req(input t_op op, input logic [31:0] a, input bit known,
                            input t_status k_st, input logic [31:0] k_addr);
        pool_resp_t r;
        @(negedge i_clk);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= a;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = pool_step(op, a);
        if (known) begin
            r.status   = k_st;
            r.blk_addr = k_addr;
        end
        resp_q.push_back(r);
        if (op == OP_ALLOC && r.status == ST_OK) live_q.push_back(r.blk_addr);
    endtask

    // Register writes only once every response is back; each write restarts the pool.
    task automatic write_reg(input t_reg_idx sel, input logic [31:0] v);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (resp_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (sel)
            REG_BASE: base_r  = v;
            REG_SIZE: size_r  = v[SIZE_W-1:0];
            default: begin
                count_r = v[CNT_W-1:0];
                n_cfg++;
            end
        endcase
        head_q  = NULL_LINK;
        fresh_q = CNT_W'(eff_count());
        used_q  = '0;
        live_q.delete();
    endtask

    // New random pool geometry; small counts dominate so the pool runs dry often.
    task automatic random_pool();
        logic [31:0]       b;
        logic [SIZE_W-1:0] sz;
        logic [CNT_W-1:0]  ct;
        case ($urandom_range(3))
            0:       b = '0;
            1:       b = 32'hFFFF_FFFF - $urandom_range(4095);
            default: b = $urandom;
        endcase
        case ($urandom_range(4))
            0:       sz = SIZE_W'($urandom_range(7));     // below minimum, zero too
            1:       sz = '1;
            2:       sz = SIZE_W'($urandom);
            default: sz = SIZE_W'($urandom_range(8, 64));
        endcase
        case ($urandom_range(9))
            0:       ct = '0;
            1:       ct = 9'd1;
            2:       ct = 9'd256;
            3:       ct = CNT_W'($urandom_range(257, 511)); // clamps to capacity
            4, 5:    ct = CNT_W'($urandom_range(1, 256));
            default: ct = CNT_W'($urandom_range(2, 16));
        endcase
        write_reg(REG_BASE, b);
        write_reg(REG_SIZE, 32'(sz));
        write_reg(REG_COUNT, 32'(ct));
    endtask

    // Mostly allocs and frees of live blocks; the rest is bad or repeated addresses.
    task automatic random_req();
        int k, j;
        longint unsigned sz, span;
        logic [31:0] a;
        sz   = eff_size();
        span = sz * eff_count();
        k    = $urandom_range(99);
        if (k < 45) begin
            push_req(OP_ALLOC, $urandom, 1'b0, ST_OK, '0);
        end else if (k < 85 && live_q.size() != 0) begin
            j = $urandom_range(live_q.size() - 1);
            a = live_q[j];
            live_q.delete(j);
            push_req(OP_FREE, a, 1'b0, ST_OK, '0);
        end else begin
            case ($urandom_range(4))
                0: a = $urandom;
                1: a = 32'(longint'(base_r) + ((span != 0) ? $urandom % span : 0));
                2: a = 32'(longint'(base_r) + sz * $urandom_range(32'(eff_count())));
                3: a = base_r - 32'($urandom_range(1, 4));
                default: a = 32'(longint'(base_r) + span + $urandom_range(7));
            endcase
            push_req(OP_FREE, a, 1'b0, ST_OK, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // Response side: random stalls plus one long hold-off on request
    // ---------------------------------------------------------------
    initial begin : rcv_drive
        int n;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    i_m_axis_tready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            i_m_axis_tready <= (rcv_pct == 0) || ($urandom_range(99) >= rcv_pct);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        pool_resp_t want, got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.status   = t_status'(o_m_axis_tdata[1:0]);
            got.blk_addr = o_m_axis_tdata[33:2];
            got.used     = o_m_axis_tdata[42:34];
            got.avail    = o_m_axis_tdata[51:43];
            got.full     = o_m_axis_tdata[52];
            n_resp++;
            st_cnt[got.status]++;
            if (resp_q.size() == 0) begin
                $error("response with no request outstanding");
                n_bad++;
            end else begin
                want = resp_q.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    n_bad++;
                end
                if (got.blk_addr !== want.blk_addr) begin
                    $error("block_address: expected %h, got %h", want.blk_addr, got.blk_addr);
                    n_bad++;
                end
                if (got.used !== want.used) begin
                    $error("used_blocks: expected %0d, got %0d", want.used, got.used);
                    n_bad++;
                end
                if (got.avail !== want.avail) begin
                    $error("free_blocks: expected %0d, got %0d", want.avail, got.avail);
                    n_bad++;
                end
                if (got.full !== want.full) begin
                    $error("pool_full: expected %0d, got %0d", want.full, got.full);
                    n_bad++;
                end
            end
        end
    end

    // watchdog: any handshake resets it
    int unsigned quiet_cyc = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cyc <= 0;
        end else if (quiet_cyc == WATCHDOG_LIMIT) begin
            $display("tb_fixed_block_pool_allocator NOT OK");
            $finish;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
        end
    end

    // ---------------------------------------------------------------
    // Directed part. After reset: base 0, size 8, 256 blocks, so the first
    // alloc is block 255 at 0x7F8.
    // ---------------------------------------------------------------
    dir_row_t dir_tab [N_ROWS] = '{
        // cfg   reg        op        value          known  status       block addr
        '{1'b0, REG_BASE,  OP_ALLOC, 32'hFFFF_FFFF, 1'b1, ST_OK,       32'h0000_07F8},
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_07F0},
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_07F8, 1'b1, ST_OK,       32'h0000_0000},
        // freed block comes straight back
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h5555_5555, 1'b1, ST_OK,       32'h0000_07F8},
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_0003, 1'b1, ST_MISALIGN, 32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_0800, 1'b1, ST_RANGE,    32'h0000_0000},
        // address zero, freed three times: double free, then used stuck at zero
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_ALLOC, 32'hAAAA_AAAA, 1'b1, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'hFFFF_FFFF, 1'b1, ST_RANGE,    32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_07FF, 1'b1, ST_MISALIGN, 32'h0000_0000},
        // pool at the top of the address space, size below minimum, 3 blocks
        '{1'b1, REG_BASE,  OP_ALLOC, 32'hFFFF_FFF0, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b1, REG_SIZE,  OP_ALLOC, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b1, REG_COUNT, OP_ALLOC, 32'h0000_0003, 1'b0, ST_OK,       32'h0000_0000},
        // top block address wraps past 2^32
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,       32'hFFFF_FFF8},
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b1, ST_OK,       32'hFFFF_FFF0},
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_0000, 1'b1, ST_RANGE,    32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'hFFFF_FFF4, 1'b1, ST_MISALIGN, 32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'hFFFF_FFF0, 1'b1, ST_OK,       32'h0000_0000},
        // zero blocks: nothing to hand out, nothing in range
        '{1'b1, REG_COUNT, OP_ALLOC, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'hFFFF_FFF0, 1'b1, ST_RANGE,    32'h0000_0000},
        // largest size, count above capacity (clamped to 256)
        '{1'b1, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b1, REG_SIZE,  OP_ALLOC, 32'h0000_FFFF, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b1, REG_COUNT, OP_ALLOC, 32'h0000_01FF, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_ALLOC, 32'h0000_0000, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'h0000_FFFF, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'h00FE_FF01, 1'b0, ST_OK,       32'h0000_0000},
        '{1'b0, REG_BASE,  OP_FREE,  32'h00FF_FF00, 1'b1, ST_RANGE,    32'h0000_0000}
    };

    initial begin : main
        dir_row_t row;
        int p, i;
        base_r  = '0;
        size_r  = SIZE_W'(8);
        count_r = CNT_W'(256);
        head_q  = NULL_LINK;
        fresh_q = CNT_W'(eff_count());
        used_q  = '0;
        n_cfg   = 1;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_ROWS; i++) begin
            row = dir_tab[i];
            if (row.is_cfg)
                write_reg(row.reg_sel, row.value);
            else
                push_req(row.op, row.value, row.known, row.k_status, row.k_addr);
        end

        // idle mixes, two pool settings each: none, sender 63%, receiver 63%, both 17%
        for (p = 0; p < N_PHASES; p++) begin
            case (p / 2)
                0: begin send_pct = 0;  rcv_pct = 0;  end
                1: begin send_pct = 63; rcv_pct = 0;  end
                2: begin send_pct = 0;  rcv_pct = 63; end
                default: begin send_pct = 17; rcv_pct = 17; end
            endcase
            random_pool();
            for (i = 0; i < PHASE_REQS; i++) begin
                // long output hold-off while requests keep coming: input must back up
                if (p == 0 && i == 60) hold_go = 1'b1;
                random_req();
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d responses: %0d ok, %0d empty, %0d out of range, %0d misaligned",
                 n_resp, st_cnt[ST_OK], st_cnt[ST_EMPTY], st_cnt[ST_RANGE],
                 st_cnt[ST_MISALIGN]);
        $display("%0d pool geometries, four idle/stall mixes, one long output hold-off",
                 n_cfg);
        if (n_bad == 0)
            $display("tb_fixed_block_pool_allocator OK");
        else
            $display("tb_fixed_block_pool_allocator NOT OK");
        $finish;
    end

endmodule

/* fixed_block_pool_allocator.f */
sv/fbpa_pkg.sv
sv/fbpa_divider.sv
sv/fixed_block_pool_allocator.sv
tb/sv/tb_fixed_block_pool_allocator.sv
